[hdl/lsd_pkg.sv]
// ----------------------------------------------------------------------------
// lsd_pkg
// Action codes and sequencer state for the LIFO stack with dump.
// ----------------------------------------------------------------------------
package lsd_pkg;

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_PEEK = 2'd2,
        ACT_DUMP = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_POP  = 3'b010,
        ST_DUMP = 3'b100
    } state_t;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 7;

endpackage

[hdl/lsd_ram.sv]
// ----------------------------------------------------------------------------
// lsd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/lifo_stack_with_dump.sv]
// ----------------------------------------------------------------------------
// lifo_stack_with_dump
// Fixed-depth LIFO of signed 32-bit elements with push, pop, peek and dump.
//
//   channel | direction | handshake        | payload
//   s_      | in        | s_valid/s_ready  | action, value
//   m_      | out       | m_valid/m_ready  | top, count, flags, dump element
//
// Push, peek, pop to empty, dump of an empty stack and refused push: one beat from idle.
// Pop that leaves elements: the new top is read from the RAM in ST_POP.
// Dump: a RAM read of the bottom element, then 1 beat per stored element through the read port.
// Reset clears the count; the RAM holds no reset and needs no clearing pass.
// A stalled m_ beat holds; a new s_ beat is taken only in ST_IDLE, when the m_ register drains.
// ----------------------------------------------------------------------------
module lifo_stack_with_dump #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_action,
    input  logic signed [31:0]         s_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [31:0]         m_top_value,
    output logic                       m_top_valid,
    output logic [6:0]                 m_item_count,
    output logic                       m_is_empty,
    output logic                       m_is_full,
    output logic                       m_overflow,
    output logic signed [31:0]         m_dump_value,
    output logic                       m_dump_valid,
    output logic                       m_last
);
    import lsd_pkg::*;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [DATA_W-1:0]   top_reg, top_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic                m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]   m_top_reg, m_top_next;
    logic [CNT_W-1:0]    m_count_reg, m_count_next;
    logic                m_ovf_reg, m_ovf_next;
    logic [DATA_W-1:0]   m_dval_reg, m_dval_next;
    logic                m_dvalid_reg, m_dvalid_next;
    logic                m_last_reg, m_last_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    logic                out_free, accept, load, dump_end;
    logic [DATA_W-1:0]   ld_top, ld_dval;
    logic [CNT_W-1:0]    ld_count;
    logic                ld_ovf, ld_dvalid, ld_last;
    action_t             action;

    lsd_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign action   = action_t'(s_action);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign dump_end = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        top_next   = top_reg;
        idx_next   = idx_reg;
        ram_we     = 1'b0;
        ram_waddr  = ADDR_W'(count_reg);
        ram_raddr  = idx_reg;
        load       = 1'b0;
        ld_top     = top_reg;
        ld_count   = count_reg;
        ld_ovf     = 1'b0;
        ld_dval    = '0;
        ld_dvalid  = 1'b0;
        ld_last    = 1'b1;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (action)
                        ACT_PUSH: begin
                            load = 1'b1;
                            if (count_reg == CNT_W'(STACK_DEPTH)) begin
                                ld_ovf = 1'b1;
                            end else begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                top_next   = s_value;
                                ld_count   = count_reg + CNT_W'(1);
                                ld_top     = s_value;
                            end
                        end
                        ACT_POP: begin
                            if (count_reg <= CNT_W'(1)) begin
                                load       = 1'b1;
                                count_next = '0;
                                ld_count   = '0;
                            end else begin
                                count_next = count_reg - CNT_W'(1);
                                ram_raddr  = ADDR_W'(count_reg - CNT_W'(2));
                                state_next = ST_POP;
                            end
                        end
                        ACT_PEEK: begin
                            load = 1'b1;
                        end
                        default: begin
                            if (count_reg == '0) begin
                                load = 1'b1;
                            end else begin
                                idx_next   = '0;
                                ram_raddr  = '0;
                                state_next = ST_DUMP;
                            end
                        end
                    endcase
                end
            end
            ST_POP: begin
                load       = 1'b1;
                top_next   = ram_rdata;
                ld_top     = ram_rdata;
                state_next = ST_IDLE;
            end
            ST_DUMP: begin
                if (out_free) begin
                    load      = 1'b1;
                    ld_dval   = ram_rdata;
                    ld_dvalid = 1'b1;
                    ld_last   = dump_end;
                    if (dump_end) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next  = idx_reg + ADDR_W'(1);
                        ram_raddr = idx_reg + ADDR_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        m_top_next    = m_top_reg;
        m_count_next  = m_count_reg;
        m_ovf_next    = m_ovf_reg;
        m_dval_next   = m_dval_reg;
        m_dvalid_next = m_dvalid_reg;
        m_last_next   = m_last_reg;
        if (load) begin
            m_valid_next  = 1'b1;
            m_top_next    = (ld_count == '0) ? '0 : ld_top;
            m_count_next  = ld_count;
            m_ovf_next    = ld_ovf;
            m_dval_next   = ld_dval;
            m_dvalid_next = ld_dvalid;
            m_last_next   = ld_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg      <= top_next;
        idx_reg      <= idx_next;
        m_top_reg    <= m_top_next;
        m_count_reg  <= m_count_next;
        m_ovf_reg    <= m_ovf_next;
        m_dval_reg   <= m_dval_next;
        m_dvalid_reg <= m_dvalid_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_top_value  = m_top_reg;
    assign m_item_count = COUNT_W'(m_count_reg);
    assign m_top_valid  = m_count_reg != '0;
    assign m_is_empty   = m_count_reg == '0;
    assign m_is_full    = m_count_reg == CNT_W'(STACK_DEPTH);
    assign m_overflow   = m_ovf_reg;
    assign m_dump_value = m_dval_reg;
    assign m_dump_valid = m_dvalid_reg;
    assign m_last       = m_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE)
        else $error("input ready outside idle");

    a_dump_top: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dump_valid && m_last |-> m_dump_value == m_top_value)
        else $error("last dump element differs from top");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> m_is_full && !m_dump_valid)
        else $error("overflow beat without full stack");
`endif

endmodule

[sim/tb_lifo_stack_with_dump.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lifo_stack_with_dump
// Drives push, pop, peek and dump beats into the stack and tracks a stack of
// its own to build every expected response beat, including dump listings,
// refused pushes and operations on an empty stack. Response beats are checked
// field by field in order, under several sender and receiver idling mixes,
// a long receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_lifo_stack_with_dump;
    import lsd_pkg::*;

    localparam int DEPTH        = 64;
    localparam int HALF_PERIOD  = 6;
    localparam int STALL_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 80;
    localparam int HOLD_CYCLES  = 250;

    typedef struct {
        logic signed [31:0] top_value;
        logic               top_valid;
        logic [6:0]         item_count;
        logic               is_empty;
        logic               is_full;
        logic               overflow;
        logic signed [31:0] dump_value;
        logic               dump_valid;
        logic               last;
    } stack_beat_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_action = '0;
    logic signed [31:0] s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_top_value;
    logic               m_top_valid;
    logic [6:0]         m_item_count;
    logic               m_is_empty;
    logic               m_is_full;
    logic               m_overflow;
    logic signed [31:0] m_dump_value;
    logic               m_dump_valid;
    logic               m_last;

    logic signed [31:0] shadow_stack [DEPTH];
    int unsigned        shadow_count = 0;
    stack_beat_t        pending_beats [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int error_count    = 0;
    int beat_index     = 0;
    int quiet_cycles   = 0;

    lifo_stack_with_dump #(
        .STACK_DEPTH (DEPTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_top_value  (m_top_value),
        .m_top_valid  (m_top_valid),
        .m_item_count (m_item_count),
        .m_is_empty   (m_is_empty),
        .m_is_full    (m_is_full),
        .m_overflow   (m_overflow),
        .m_dump_value (m_dump_value),
        .m_dump_valid (m_dump_valid),
        .m_last       (m_last)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    function automatic stack_beat_t status_beat(logic ovf, logic signed [31:0] dval,
                                                logic dvalid, logic fin);
        stack_beat_t b;
        b.top_value  = (shadow_count > 0) ? shadow_stack[shadow_count - 1] : '0;
        b.top_valid  = (shadow_count > 0);
        b.item_count = shadow_count[6:0];
        b.is_empty   = (shadow_count == 0);
        b.is_full    = (shadow_count == DEPTH);
        b.overflow   = ovf;
        b.dump_value = dval;
        b.dump_valid = dvalid;
        b.last       = fin;
        return b;
    endfunction

    task automatic apply_action(action_t act, logic signed [31:0] val);
        case (act)
            ACT_PUSH: begin
                if (shadow_count >= DEPTH) begin
                    pending_beats.push_back(status_beat(1'b1, '0, 1'b0, 1'b1));
                end else begin
                    shadow_stack[shadow_count] = val;
                    shadow_count++;
                    pending_beats.push_back(status_beat(1'b0, '0, 1'b0, 1'b1));
                end
            end
            ACT_POP: begin
                if (shadow_count > 0) shadow_count--;
                pending_beats.push_back(status_beat(1'b0, '0, 1'b0, 1'b1));
            end
            ACT_PEEK: begin
                pending_beats.push_back(status_beat(1'b0, '0, 1'b0, 1'b1));
            end
            default: begin
                if (shadow_count == 0) begin
                    pending_beats.push_back(status_beat(1'b0, '0, 1'b0, 1'b1));
                end else begin
                    for (int i = 0; i < shadow_count; i++) begin
                        pending_beats.push_back(status_beat(1'b0, shadow_stack[i], 1'b1,
                                                            i == shadow_count - 1));
                    end
                end
            end
        endcase
    endtask

    task automatic send_beat(action_t act, logic signed [31:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= act;
        s_value  <= val;
        do @(posedge aclk); while (!s_ready);
        apply_action(act, val);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_beats.size() > 0) @(posedge aclk);
    endtask

    task automatic set_idling(int sender_pct, int receiver_pct);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("ERROR beat %0d %s: got %h expected %h", beat_index, what, got, want);
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // receiver: random stall, or hold off for a requested stretch
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        stack_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_beats.size() == 0) begin
                report_mismatch("unexpected beat", m_top_value, '0);
            end else begin
                want = pending_beats.pop_front();
                check_field("top_value", m_top_value, want.top_value);
                check_field("top_valid", m_top_valid, want.top_valid);
                check_field("item_count", m_item_count, want.item_count);
                check_field("is_empty", m_is_empty, want.is_empty);
                check_field("is_full", m_is_full, want.is_full);
                check_field("overflow", m_overflow, want.overflow);
                check_field("dump_value", m_dump_value, want.dump_value);
                check_field("dump_valid", m_dump_valid, want.dump_valid);
                check_field("last", m_last, want.last);
            end
            beat_index++;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_empty_stack();
        send_beat(ACT_PEEK, 32'sd0);
        send_beat(ACT_POP, 32'sd0);
        send_beat(ACT_DUMP, 32'sd0);
        send_beat(ACT_POP, 32'h7FFF_FFFF);
    endtask

    task automatic test_value_extremes();
        send_beat(ACT_PUSH, 32'sh8000_0000);
        send_beat(ACT_PUSH, 32'sh7FFF_FFFF);
        send_beat(ACT_PUSH, 32'sd0);
        send_beat(ACT_PUSH, -32'sd1);
        send_beat(ACT_PUSH, 32'sh5555_5555);
        send_beat(ACT_PUSH, 32'shAAAA_AAAA);
        send_beat(ACT_PEEK, 32'sh1234_5678);
        send_beat(ACT_DUMP, -32'sd1);
        send_beat(ACT_POP, 32'sd0);
        send_beat(ACT_PEEK, 32'sd0);
        send_beat(ACT_POP, 32'sd0);
        send_beat(ACT_DUMP, 32'sd0);
        repeat (4) send_beat(ACT_POP, 32'sd0);
        send_beat(ACT_POP, 32'sd0);
        send_beat(ACT_DUMP, 32'sd0);
    endtask

    task automatic test_fill_and_overflow();
        while (shadow_count < DEPTH) send_beat(ACT_PUSH, $urandom);
        send_beat(ACT_PUSH, $urandom);
        send_beat(ACT_PEEK, $urandom);
        send_beat(ACT_PUSH, $urandom);
        send_beat(ACT_DUMP, $urandom);
        while (shadow_count > 0) send_beat(ACT_POP, $urandom);
        send_beat(ACT_POP, $urandom);
    endtask

    task automatic test_random_traffic(int n_items);
        int      roll;
        int      pop_share;
        action_t act;
        for (int n = 0; n < n_items; n++) begin
            roll      = $urandom_range(99);
            pop_share = (shadow_count > 48) ? 55 : 30;
            if (roll < 8) act = ACT_DUMP;
            else if (roll < 18) act = ACT_PEEK;
            else if (roll < 18 + pop_share) act = ACT_POP;
            else act = ACT_PUSH;
            send_beat(act, $urandom);
        end
    endtask

    task automatic test_receiver_hold_off();
        hold_left = HOLD_CYCLES;
        set_idling(0, 0);
        test_random_traffic(30);
        wait_drained();
    endtask

    task automatic test_drain_pause();
        set_idling(27, 27);
        test_random_traffic(15);
        wait_drained();
        test_random_traffic(15);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idling(0, 0);
        test_empty_stack();
        test_value_extremes();
        set_idling(27, 27);
        test_fill_and_overflow();

        set_idling(0, 0);
        test_random_traffic(30);
        set_idling(77, 0);
        test_random_traffic(30);
        set_idling(0, 77);
        test_random_traffic(30);
        set_idling(27, 27);
        test_random_traffic(30);

        test_receiver_hold_off();
        test_drain_pause();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
